// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMP(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rn, a, b) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ck, rn, a, b)
`define ASSERT_NEXT(lbl, ck, rn, a, b)
`endif

`endif

// ----- rtl/hbmt_pkg.sv -----
package hbmt_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [7:0] PING_PERIOD_RST  = 8'd5;
    localparam logic [7:0] REMOVE_DELAY_RST = 8'd20;

    typedef enum logic [1:0] {
        CMD_JOIN   = 2'd0,
        CMD_JREPLY = 2'd1,
        CMD_HB     = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        K_HB      = 3'd0,
        K_REPLY   = 3'd1,
        K_ADDED   = 3'd2,
        K_REMOVED = 3'd3,
        K_UPDATED = 3'd4,
        K_STALE   = 3'd5,
        K_DUP     = 3'd6,
        K_FULL    = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        CFG_OWN_ID       = 3'd0,
        CFG_OWN_PORT     = 3'd1,
        CFG_PING_PERIOD  = 3'd2,
        CFG_REMOVE_DELAY = 3'd3,
        CFG_STARTS_GROUP = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_REPLY_SCAN,
        ST_JOIN_HB,
        ST_PURGE,
        ST_HB_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] hb;
    } item_t;

    typedef struct packed {
        logic [31:0] id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] seen;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] dest_id;
        logic [15:0] dest_port;
        logic [31:0] entry_id;
        logic [15:0] entry_port;
        logic [31:0] entry_hb;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    done;
        result_t res;
    } emit_t;

endpackage

// ----- rtl/hbmt_front.sv -----
module hbmt_front
    import hbmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // member_id, member_port, heartbeat_value
    input  logic [1:0]  s_tuser,   // command
    output logic        item_valid,
    input  logic        item_ready,
    output item_t       item
);

    item_t       q_reg [2];
    logic        wp_reg, wp_next;
    logic        rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;
    item_t       in_item;

    assign s_tready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_reg[rp_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_valid && item_ready;

    always_comb
    begin
        in_item.cmd  = cmd_t'(s_tuser);
        in_item.id   = s_tdata[31:0];
        in_item.port = s_tdata[47:32];
        in_item.hb   = s_tdata[79:48];
        wp_next      = push ? ~wp_reg : wp_reg;
        rp_next      = pop ? ~rp_reg : rp_reg;
        cnt_next     = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_item;
        end
    end

endmodule

// ----- rtl/hbmt_engine.sv -----
`include "assert_macros.svh"
module hbmt_engine
    import hbmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        item_valid,
    output logic        item_ready,
    input  item_t       item,
    input  logic        room,
    output emit_t       emit
);

    state_t             st_reg, st_next;
    item_t              cur_reg;
    entry_t             ent_reg [DEPTH];
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   wr_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   fidx_reg;
    logic [31:0]        own_id_reg;
    logic [15:0]        own_port_reg;
    logic [7:0]         period_reg;
    logic [7:0]         delay_reg;
    logic               in_group_reg;
    logic [31:0]        time_reg;
    logic [31:0]        own_hb_reg;
    logic [7:0]         cd_reg;

    logic [IDX_W-1:0]   rd_addr;
    entry_t             rd;
    logic               scan_end;
    logic               full;
    logic               hit;
    logic               expired;
    logic               newer;
    logic [8:0]         limit;
    logic [31:0]        age;

    always_comb
    begin
        rd_addr  = (st_reg == ST_DECIDE) ? fidx_reg : idx_reg[IDX_W-1:0];
        rd       = ent_reg[rd_addr];
        scan_end = (idx_reg == n_reg);
        full     = (n_reg == CNT_W'(DEPTH));
        hit      = (rd.id == cur_reg.id) && (rd.port == cur_reg.port);
        limit    = {1'b0, period_reg} + {1'b0, delay_reg};
        age      = time_reg - rd.seen;
        expired  = (age > {23'd0, limit});
        newer    = (cur_reg.hb >= rd.hb);
    end

    assign item_ready = (st_reg == ST_IDLE) && room;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.cmd == CMD_TICK)
                        st_next = in_group_reg ? ST_PURGE : ST_DONE;
                    else
                        st_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (scan_end || hit)
                    st_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                unique case (cur_reg.cmd)
                    CMD_JOIN:   st_next = (found_reg || full) ? ST_DONE : ST_REPLY_SCAN;
                    CMD_JREPLY: st_next = (found_reg || full) ? ST_DONE : ST_JOIN_HB;
                    default:    st_next = ST_DONE;
                endcase
            end
            ST_REPLY_SCAN:
            begin
                if (scan_end)
                    st_next = ST_DONE;
            end
            ST_JOIN_HB:
            begin
                st_next = ST_DONE;
            end
            ST_PURGE:
            begin
                if (scan_end)
                    st_next = (cd_reg <= 8'd1) ? ST_HB_SCAN : ST_DONE;
            end
            ST_HB_SCAN:
            begin
                if (scan_end)
                    st_next = ST_DONE;
            end
            ST_DONE:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        emit       = '0;
        emit.valid = 1'b0;
        unique case (st_reg)
            ST_DECIDE:
            begin
                emit.valid          = 1'b1;
                emit.res.entry_id   = cur_reg.id;
                emit.res.entry_port = cur_reg.port;
                emit.res.entry_hb   = cur_reg.hb;
                if (found_reg && (cur_reg.cmd != CMD_HB))
                    emit.res.kind = K_DUP;
                else if (found_reg)
                begin
                    emit.res.kind = newer ? K_UPDATED : K_STALE;
                    if (!newer)
                        emit.res.entry_hb = rd.hb;
                end
                else if (full)
                    emit.res.kind = K_FULL;
                else if (cur_reg.cmd == CMD_JOIN)
                begin
                    emit.res.kind       = K_REPLY;
                    emit.res.dest_id    = cur_reg.id;
                    emit.res.dest_port  = cur_reg.port;
                    emit.res.entry_id   = own_id_reg;
                    emit.res.entry_port = own_port_reg;
                    emit.res.entry_hb   = own_hb_reg;
                end
                else
                    emit.res.kind = K_ADDED;
            end
            ST_REPLY_SCAN:
            begin
                emit.valid = 1'b1;
                if (scan_end)
                begin
                    emit.res.kind       = K_ADDED;
                    emit.res.entry_id   = cur_reg.id;
                    emit.res.entry_port = cur_reg.port;
                    emit.res.entry_hb   = cur_reg.hb;
                end
                else
                begin
                    emit.res.kind       = K_REPLY;
                    emit.res.dest_id    = cur_reg.id;
                    emit.res.dest_port  = cur_reg.port;
                    emit.res.entry_id   = rd.id;
                    emit.res.entry_port = rd.port;
                    emit.res.entry_hb   = rd.hb;
                end
            end
            ST_JOIN_HB:
            begin
                emit.valid          = 1'b1;
                emit.res.kind       = K_HB;
                emit.res.dest_id    = cur_reg.id;
                emit.res.dest_port  = cur_reg.port;
                emit.res.entry_id   = own_id_reg;
                emit.res.entry_port = own_port_reg;
                emit.res.entry_hb   = own_hb_reg;
            end
            ST_PURGE:
            begin
                emit.valid          = !scan_end && expired;
                emit.res.kind       = K_REMOVED;
                emit.res.entry_id   = rd.id;
                emit.res.entry_port = rd.port;
                emit.res.entry_hb   = rd.hb;
            end
            ST_HB_SCAN:
            begin
                emit.valid          = !scan_end;
                emit.res.kind       = K_HB;
                emit.res.dest_id    = rd.id;
                emit.res.dest_port  = rd.port;
                emit.res.entry_id   = own_id_reg;
                emit.res.entry_port = own_port_reg;
                emit.res.entry_hb   = own_hb_reg;
            end
            ST_DONE:
            begin
                emit.done = 1'b1;
            end
            default:
            begin
                emit.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            n_reg        <= '0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            found_reg    <= 1'b0;
            fidx_reg     <= '0;
            own_id_reg   <= '0;
            own_port_reg <= '0;
            period_reg   <= PING_PERIOD_RST;
            delay_reg    <= REMOVE_DELAY_RST;
            in_group_reg <= 1'b0;
            time_reg     <= '0;
            own_hb_reg   <= '0;
            cd_reg       <= PING_PERIOD_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_OWN_ID:       own_id_reg   <= cfg_data;
                    CFG_OWN_PORT:     own_port_reg <= cfg_data[15:0];
                    CFG_PING_PERIOD:  period_reg   <= cfg_data[7:0];
                    CFG_REMOVE_DELAY: delay_reg    <= cfg_data[7:0];
                    CFG_STARTS_GROUP: in_group_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (room)
            begin
                st_reg <= st_next;
                unique case (st_reg)
                    ST_IDLE:
                    begin
                        idx_reg   <= '0;
                        wr_reg    <= '0;
                        found_reg <= 1'b0;
                        if (item_valid && (item.cmd == CMD_TICK))
                            time_reg <= time_reg + 32'd1;
                    end
                    ST_SEARCH:
                    begin
                        if (!scan_end)
                        begin
                            if (hit)
                            begin
                                found_reg <= 1'b1;
                                fidx_reg  <= idx_reg[IDX_W-1:0];
                            end
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    ST_DECIDE:
                    begin
                        idx_reg <= '0;
                        if (cur_reg.cmd == CMD_JREPLY)
                            in_group_reg <= 1'b1;
                        if (!found_reg && !full && (cur_reg.cmd != CMD_JOIN))
                            n_reg <= n_reg + 1'b1;
                    end
                    ST_REPLY_SCAN:
                    begin
                        if (scan_end)
                            n_reg <= n_reg + 1'b1;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    ST_PURGE:
                    begin
                        if (scan_end)
                        begin
                            n_reg   <= wr_reg;
                            idx_reg <= '0;
                            if (cd_reg <= 8'd1)
                            begin
                                own_hb_reg <= own_hb_reg + 32'd1;
                                cd_reg     <= period_reg;
                            end
                            else
                                cd_reg <= cd_reg - 8'd1;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            if (!expired)
                                wr_reg <= wr_reg + 1'b1;
                        end
                    end
                    ST_HB_SCAN:
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (room)
        begin
            if ((st_reg == ST_IDLE) && item_valid)
                cur_reg <= item;
            if ((st_reg == ST_DECIDE) && found_reg && (cur_reg.cmd == CMD_HB) && newer)
            begin
                ent_reg[fidx_reg].hb   <= cur_reg.hb;
                ent_reg[fidx_reg].seen <= time_reg;
            end
            if (((st_reg == ST_DECIDE) && !found_reg && !full && (cur_reg.cmd != CMD_JOIN))
                || ((st_reg == ST_REPLY_SCAN) && scan_end))
            begin
                ent_reg[n_reg[IDX_W-1:0]] <= '{id: cur_reg.id, port: cur_reg.port,
                                               hb: cur_reg.hb, seen: time_reg};
            end
            if ((st_reg == ST_PURGE) && !scan_end && !expired)
                ent_reg[wr_reg[IDX_W-1:0]] <= rd;
        end
    end

    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, n_reg <= CNT_W'(DEPTH))
    `ASSERT_IMP(a_emit_room, clk, rst_n, emit.valid || emit.done, room || !item_ready)
    `ASSERT_IMP(a_idle_quiet, clk, rst_n, st_reg == ST_IDLE, !emit.valid && !emit.done)
    `ASSERT_NEXT(a_purge_shrinks, clk, rst_n, (st_reg == ST_PURGE) && scan_end && room, n_reg <= $past(n_reg))

endmodule

// ----- rtl/hbmt_out.sv -----
module hbmt_out
    import hbmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  emit_t        emit,
    output logic         room,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // dest_id, dest_port, entry_id, entry_port, entry_heartbeat
    output logic [2:0]   m_tuser,  // kind
    output logic         m_tlast
);

    result_t pend_reg;
    logic    pend_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    logic    last_reg;

    assign room     = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = last_reg;
    assign m_tdata  = {out_reg.entry_hb, out_reg.entry_port, out_reg.entry_id,
                       out_reg.dest_port, out_reg.dest_id};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (room && (emit.valid || (emit.done && pend_valid_reg)))
        begin
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= emit.valid;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (room && (emit.valid || emit.done) && pend_valid_reg)
        begin
            out_reg  <= pend_reg;
            last_reg <= emit.done;
        end
        if (room && emit.valid)
            pend_reg <= emit.res;
    end

endmodule

// ----- rtl/heartbeat_membership_table.sv -----
// The engine takes a new item only once it is through with the last one; its table
// scans read one entry a cycle while the output has room for results.
// Each result waits in a holding register until the next one or the end of its item.
// Reset: asynchronous, clears the table count, time, heartbeat and control; registers to defaults.
module heartbeat_membership_table
    import hbmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,  // member_id, member_port, heartbeat_value
    input  logic [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,  // dest_id, dest_port, entry_id, entry_port, entry_heartbeat
    output logic [2:0]   m_tuser,  // kind
    output logic         m_tlast
);

    logic  item_valid;
    logic  item_ready;
    item_t item;
    logic  room;
    emit_t emit;

    hbmt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    hbmt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .room       (room),
        .emit       (emit)
    );

    hbmt_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- bench/hbmt_checker.sv -----
`timescale 1ns / 100ps

module hbmt_checker
    import hbmt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [79:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    output int           fail_count,
    output int           pending,
    output int           words_seen
);

    typedef struct {
        kind_t       kind;
        logic [31:0] dest_id;
        logic [15:0] dest_port;
        logic [31:0] ent_id;
        logic [15:0] ent_port;
        logic [31:0] ent_hb;
        logic        last;
    } outcome_t;

    outcome_t    outcome_q[$];

    logic [31:0] my_id;
    logic [15:0] my_port;
    logic [7:0]  period;
    logic [7:0]  linger;
    logic [31:0] mem_id[DEPTH];
    logic [15:0] mem_port[DEPTH];
    logic [31:0] mem_hb[DEPTH];
    logic [31:0] mem_seen[DEPTH];
    int          members;
    logic [31:0] now;
    logic [31:0] my_hb;
    logic [7:0]  countdown;
    logic        grouped;

    assign pending = outcome_q.size();

    function automatic void push(kind_t k, logic [31:0] did, logic [15:0] dport,
                                 logic [31:0] eid, logic [15:0] eport, logic [31:0] ehb);
        outcome_t o;
        o.kind = k;
        o.dest_id = did;
        o.dest_port = dport;
        o.ent_id = eid;
        o.ent_port = eport;
        o.ent_hb = ehb;
        o.last = 1'b0;
        outcome_q.insert(outcome_q.size(), o);
    endfunction

    function automatic int lookup(logic [31:0] id, logic [15:0] port);
        for (int i = 0; i < members; i++)
            if (mem_id[i] == id && mem_port[i] == port)
                return i;
        return -1;
    endfunction

    function automatic void enroll(logic [31:0] id, logic [15:0] port, logic [31:0] hb);
        mem_id[members] = id;
        mem_port[members] = port;
        mem_hb[members] = hb;
        mem_seen[members] = now;
        members++;
    endfunction

    function automatic void membership_step(cmd_t cmd, logic [31:0] id, logic [15:0] port,
                                            logic [31:0] hb);
        int          start;
        int          k;
        int          i;
        logic [31:0] limit;
        start = outcome_q.size();
        k = lookup(id, port);
        case (cmd)
            CMD_JOIN:
            begin
                if (k >= 0)
                    push(K_DUP, 32'd0, 16'd0, id, port, hb);
                else if (members >= DEPTH)
                    push(K_FULL, 32'd0, 16'd0, id, port, hb);
                else
                begin
                    push(K_REPLY, id, port, my_id, my_port, my_hb);
                    for (int j = 0; j < members; j++)
                        push(K_REPLY, id, port, mem_id[j], mem_port[j], mem_hb[j]);
                    enroll(id, port, hb);
                    push(K_ADDED, 32'd0, 16'd0, id, port, hb);
                end
            end
            CMD_JREPLY:
            begin
                if (k >= 0)
                    push(K_DUP, 32'd0, 16'd0, id, port, hb);
                else if (members >= DEPTH)
                    push(K_FULL, 32'd0, 16'd0, id, port, hb);
                else
                begin
                    enroll(id, port, hb);
                    push(K_ADDED, 32'd0, 16'd0, id, port, hb);
                    push(K_HB, id, port, my_id, my_port, my_hb);
                end
                grouped = 1'b1;
            end
            CMD_HB:
            begin
                if (k >= 0)
                begin
                    if (hb >= mem_hb[k])
                    begin
                        mem_hb[k] = hb;
                        mem_seen[k] = now;
                        push(K_UPDATED, 32'd0, 16'd0, id, port, hb);
                    end
                    else
                        push(K_STALE, 32'd0, 16'd0, id, port, mem_hb[k]);
                end
                else if (members < DEPTH)
                begin
                    enroll(id, port, hb);
                    push(K_ADDED, 32'd0, 16'd0, id, port, hb);
                end
                else
                    push(K_FULL, 32'd0, 16'd0, id, port, hb);
            end
            default:
            begin
                now = now + 32'd1;
                if (grouped)
                begin
                    limit = 32'(period) + 32'(linger);
                    i = 0;
                    while (i < members)
                    begin
                        if (now - mem_seen[i] > limit)
                        begin
                            push(K_REMOVED, 32'd0, 16'd0, mem_id[i], mem_port[i], mem_hb[i]);
                            for (int j = i; j + 1 < members; j++)
                            begin
                                mem_id[j] = mem_id[j + 1];
                                mem_port[j] = mem_port[j + 1];
                                mem_hb[j] = mem_hb[j + 1];
                                mem_seen[j] = mem_seen[j + 1];
                            end
                            members--;
                        end
                        else
                            i++;
                    end
                    if (countdown <= 8'd1)
                    begin
                        my_hb = my_hb + 32'd1;
                        for (int j = 0; j < members; j++)
                            push(K_HB, mem_id[j], mem_port[j], my_id, my_port, my_hb);
                        countdown = period;
                    end
                    else
                        countdown = countdown - 8'd1;
                end
            end
        endcase
        if (outcome_q.size() > start)
            outcome_q[outcome_q.size() - 1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            my_id = 0;
            my_port = 0;
            period = PING_PERIOD_RST;
            linger = REMOVE_DELAY_RST;
            members = 0;
            now = 0;
            my_hb = 0;
            countdown = PING_PERIOD_RST;
            grouped = 1'b0;
            fail_count = 0;
            words_seen = 0;
            outcome_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_seen++;
                if (outcome_q.size() == 0)
                begin
                    $error("unexpected result word kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    o = outcome_q.pop_front();
                    if (m_tuser !== o.kind)
                    begin
                        $error("kind: expected %0d, got %0d", o.kind, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== o.dest_id)
                    begin
                        $error("dest_id: expected %h, got %h", o.dest_id, m_tdata[31:0]);
                        fail_count++;
                    end
                    if (m_tdata[47:32] !== o.dest_port)
                    begin
                        $error("dest_port: expected %h, got %h", o.dest_port, m_tdata[47:32]);
                        fail_count++;
                    end
                    if (m_tdata[79:48] !== o.ent_id)
                    begin
                        $error("entry_id: expected %h, got %h", o.ent_id, m_tdata[79:48]);
                        fail_count++;
                    end
                    if (m_tdata[95:80] !== o.ent_port)
                    begin
                        $error("entry_port: expected %h, got %h", o.ent_port, m_tdata[95:80]);
                        fail_count++;
                    end
                    if (m_tdata[127:96] !== o.ent_hb)
                    begin
                        $error("entry_heartbeat: expected %h, got %h", o.ent_hb,
                               m_tdata[127:96]);
                        fail_count++;
                    end
                    if (m_tlast !== o.last)
                    begin
                        $error("last: expected %b, got %b", o.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OWN_ID:       my_id = cfg_data;
                    CFG_OWN_PORT:     my_port = cfg_data[15:0];
                    CFG_PING_PERIOD:  period = cfg_data[7:0];
                    CFG_REMOVE_DELAY: linger = cfg_data[7:0];
                    CFG_STARTS_GROUP: grouped = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                membership_step(cmd_t'(s_tuser), s_tdata[31:0], s_tdata[47:32],
                                s_tdata[79:48]);
        end
    end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import hbmt_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;   // member_id, member_port, heartbeat_value
    logic [1:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // dest_id, dest_port, entry_id, entry_port, entry_heartbeat
    logic [2:0]   m_tuser;   // kind
    logic         m_tlast;

    int           fail_count;
    int           pending;
    int           words_seen;
    int           send_idle;
    int           recv_idle;
    int           words_sent;
    logic         hold_start;
    logic         held;
    int           hold_cnt;
    logic [31:0]  peer_id[40];
    logic [15:0]  peer_port[40];

    heartbeat_membership_table i_dut (.*);

    hbmt_checker i_checker (.*);

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
            held <= 1'b0;
        end
        else if (hold_start && !held)
        begin
            held <= 1'b1;
            hold_cnt <= 600;
            m_tready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    task automatic send_word(cmd_t cmd, logic [31:0] id, logic [15:0] port, logic [31:0] hb);
        while ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {hb, port, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word(int nmax);
        int          r;
        int          p;
        cmd_t        cmd;
        logic [15:0] port;
        r = $urandom_range(0, 99);
        p = $urandom_range(0, nmax - 1);
        port = peer_port[p];
        if (r < 20)
            cmd = CMD_JOIN;
        else if (r < 35)
            cmd = CMD_JREPLY;
        else if (r < 70)
            cmd = CMD_HB;
        else
            cmd = CMD_TICK;
        if ($urandom_range(0, 19) == 0)
            port = 16'($urandom);
        send_word(cmd, peer_id[p], port, $urandom);
    endtask

    initial
    begin
        send_idle = 31;
        recv_idle = 55;
        words_sent = 0;
        hold_start = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_OWN_ID;
        cfg_data = 0;
        s_tvalid = 1'b0;
        s_tdata = 0;
        s_tuser = CMD_JOIN;
        rst_n = 1'b0;
        for (int i = 0; i < 40; i++)
        begin
            peer_id[i] = $urandom;
            peer_port[i] = 16'($urandom);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, out of group
        send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_JOIN, 32'h0, 16'h0, 32'h0);
        send_word(CMD_JOIN, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF);
        send_word(CMD_JOIN, 32'h0, 16'h0, 32'h5);
        send_word(CMD_HB, 32'hFFFFFFFF, 16'hFFFF, 32'h0);
        send_word(CMD_HB, 32'h0, 16'h0, 32'h7);
        send_word(CMD_HB, 32'h0, 16'h0, 32'h7);
        send_word(CMD_HB, 32'h1234, 16'h55, 32'h9);
        send_word(CMD_JREPLY, 32'hA5A5A5A5, 16'h5A5A, 32'h3);
        send_word(CMD_JREPLY, 32'hA5A5A5A5, 16'h5A5A, 32'h3);
        send_word(CMD_JOIN, 32'hA5A5A5A5, 16'h1, 32'h1);
        repeat (6) send_word(CMD_TICK, $urandom, 16'($urandom), $urandom);
        drain();

        write_reg(CFG_OWN_ID, 32'hFFFFFFFF);
        write_reg(CFG_OWN_PORT, 32'h0000FFFF);
        write_reg(CFG_PING_PERIOD, 32'd1);
        write_reg(CFG_REMOVE_DELAY, 32'd0);
        write_reg(CFG_STARTS_GROUP, 32'd1);
        repeat (3) send_word(CMD_TICK, 0, 0, 0);
        send_word(CMD_HB, 32'h77, 16'h77, 32'h1);
        send_word(CMD_TICK, 0, 0, 0);
        for (int i = 0; i < 60; i++)
            random_word(40);
        drain();

        // receiver fast, sender slow; fill the table
        send_idle = 55;
        recv_idle = 31;
        write_reg(CFG_OWN_ID, $urandom);
        write_reg(CFG_OWN_PORT, $urandom);
        write_reg(CFG_PING_PERIOD, 32'd255);
        write_reg(CFG_REMOVE_DELAY, 32'd255);
        write_reg(CFG_STARTS_GROUP, 32'd0);
        for (int i = 0; i < 36; i++)
            send_word(CMD_JOIN, peer_id[i], peer_port[i], $urandom);
        send_word(CMD_JREPLY, 32'hDEAD, 16'hBEEF, 32'h1);
        for (int i = 0; i < 30; i++)
            random_word(40);
        drain();

        // no idling; long receiver hold-off while words keep coming
        send_idle = 0;
        recv_idle = 0;
        write_reg(CFG_PING_PERIOD, 32'd3);
        write_reg(CFG_REMOVE_DELAY, 32'd4);
        write_reg(CFG_STARTS_GROUP, 32'd1);
        hold_start <= 1'b1;
        for (int i = 0; i < 40; i++)
            random_word(32);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int i = 0; i < 40; i++)
            random_word(20);
        drain();

        if (fail_count == 0)
        begin
            $display("Covered %0d input words, %0d result words, reset and three written setups.",
                     words_sent, words_seen);
            $display("Test completed successfully");
        end
        else
        begin
            $display("Covered %0d input words, %0d result words, %0d mismatches.",
                     words_sent, words_seen, fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial
    begin
        #4ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
